[hw/rtl/mau_pkg.sv]
// ----------------------------------------------------------------------------
// mau_pkg
// Shared types and constants of the modular arithmetic unit: operation
// modes, datapath commands and the datapath status word.
// ----------------------------------------------------------------------------
package mau_pkg;

  localparam int RESIDUE_BITS_DEF = 31;
  localparam int MODE_BITS        = 3;
  localparam int RAW_BITS         = 64;

  localparam logic [MODE_BITS-1:0] MODE_REDUCE = 3'd0;
  localparam logic [MODE_BITS-1:0] MODE_ADD    = 3'd1;
  localparam logic [MODE_BITS-1:0] MODE_SUB    = 3'd2;
  localparam logic [MODE_BITS-1:0] MODE_MUL    = 3'd3;
  localparam logic [MODE_BITS-1:0] MODE_DIV    = 3'd4;
  localparam logic [MODE_BITS-1:0] MODE_POW    = 3'd5;
  localparam logic [MODE_BITS-1:0] MODE_NEG    = 3'd6;
  localparam logic [MODE_BITS-1:0] MODE_INV    = 3'd7;

  typedef enum logic [4:0] {
    OP_NOP,
    OP_LOAD,
    OP_DIV_STEP,
    OP_MUL_STEP,
    OP_WB_RA,
    OP_WB_RB,
    OP_DIV_RAW,
    OP_WB_RAW,
    OP_SIMPLE,
    OP_MUL_AB,
    OP_POW_ONE,
    OP_POW_INIT,
    OP_MUL_SQ,
    OP_WB_ACC,
    OP_MUL_BASE,
    OP_EXP_SHIFT,
    OP_WB_ACC_SHIFT,
    OP_RES_ACC,
    OP_EUC_INIT,
    OP_EUC_DIV,
    OP_MUL_QT,
    OP_EUC_T,
    OP_EUC_END,
    OP_MUL_INV,
    OP_WB_RES,
    OP_OUT
  } dp_op_t;

  typedef struct packed {
    logic [MODE_BITS-1:0] mode;
    logic                 cnt_zero;
    logic                 ecnt_zero;
    logic                 r1_zero;
    logic                 r0_one;
    logic                 ex_top;
  } dp_status_t;

endpackage

[hw/rtl/mau_datapath.sv]
// ----------------------------------------------------------------------------
// mau_datapath
// Operand registers, a bit-serial restoring divider and a bit-serial
// double-and-add modular multiplier, driven one command per cycle.
// ----------------------------------------------------------------------------
module mau_datapath #(
  parameter int RESIDUE_BITS = mau_pkg::RESIDUE_BITS_DEF
) (
  input  logic                             clk,
  input  mau_pkg::dp_op_t                  cmd,
  output mau_pkg::dp_status_t              status,
  input  logic [RESIDUE_BITS-1:0]          modulus,
  input  logic [mau_pkg::MODE_BITS-1:0]    in_mode,
  input  logic [RESIDUE_BITS-1:0]          in_operand_a,
  input  logic [RESIDUE_BITS-1:0]          in_operand_b,
  input  logic [mau_pkg::RAW_BITS-1:0]     in_raw_value,
  input  logic [mau_pkg::RAW_BITS-1:0]     in_exponent,
  output logic [RESIDUE_BITS-1:0]          out_result,
  output logic                             out_no_inverse,
  output logic                             out_equal,
  output logic                             out_less
);

  localparam int W   = RESIDUE_BITS;
  localparam int SHW = mau_pkg::RAW_BITS;
  localparam int CW  = $clog2(SHW + 1);
  localparam int EW  = SHW - 1;
  localparam int ECW = $clog2(EW + 1);

  logic [mau_pkg::MODE_BITS-1:0] mode_q;
  logic [W-1:0]   b_in;
  logic [SHW-1:0] raw_q, ex_q, sh;
  logic [W-1:0]   ra, rb, r0, r1, t0, t1, acc, pa, mx, dv, rem, res_q;
  logic [CW-1:0]  cnt;
  logic [ECW-1:0] ecnt;
  logic           noinv_q;

  logic [W-1:0]   m_eff, one;
  logic [W:0]     div_t, div_d;
  logic           div_ge;
  logic [W-1:0]   rem_step, dbl, pa_step;
  logic [SHW-1:0] raw_mag;

  function automatic logic [W-1:0] add_mod(input logic [W-1:0] x, input logic [W-1:0] y,
                                           input logic [W-1:0] m);
    logic [W:0] s;
    logic [W:0] d;
    s = {1'b0, x} + {1'b0, y};
    d = s - {1'b0, m};
    return (s >= {1'b0, m}) ? d[W-1:0] : s[W-1:0];
  endfunction

  function automatic logic [W-1:0] neg_mod(input logic [W-1:0] x, input logic [W-1:0] m);
    return (x == '0) ? '0 : m - x;
  endfunction

  // A modulus register of zero behaves as modulus one.
  assign m_eff = (modulus == '0) ? W'(1) : modulus;
  assign one   = (m_eff == W'(1)) ? '0 : W'(1);

  assign div_t    = {rem, sh[SHW-1]};
  assign div_d    = div_t - {1'b0, dv};
  assign div_ge   = (div_t >= {1'b0, dv});
  assign rem_step = div_ge ? div_d[W-1:0] : div_t[W-1:0];

  // MSB-first product: pa = 2*pa (+ mx when the multiplier bit is set).
  assign dbl     = add_mod(pa, pa, m_eff);
  assign pa_step = sh[SHW-1] ? add_mod(dbl, mx, m_eff) : dbl;

  assign raw_mag = raw_q[SHW-1] ? (~raw_q + SHW'(1)) : raw_q;

  always_ff @(posedge clk) begin
    case (cmd)
      mau_pkg::OP_LOAD: begin
        mode_q  <= in_mode;
        b_in    <= in_operand_b;
        raw_q   <= in_raw_value;
        ex_q    <= in_exponent;
        noinv_q <= 1'b0;
        res_q   <= '0;
        sh      <= {in_operand_a, {(SHW-W){1'b0}}};
        rem     <= '0;
        dv      <= m_eff;
        cnt     <= CW'(W);
      end
      mau_pkg::OP_DIV_STEP: begin
        rem <= rem_step;
        sh  <= {sh[SHW-2:0], div_ge};
        cnt <= cnt - CW'(1);
      end
      mau_pkg::OP_MUL_STEP: begin
        pa  <= pa_step;
        sh  <= {sh[SHW-2:0], 1'b0};
        cnt <= cnt - CW'(1);
      end
      mau_pkg::OP_WB_RA: begin
        ra  <= rem;
        sh  <= {b_in, {(SHW-W){1'b0}}};
        rem <= '0;
        cnt <= CW'(W);
      end
      mau_pkg::OP_WB_RB: begin
        rb <= rem;
      end
      mau_pkg::OP_DIV_RAW: begin
        sh  <= raw_mag;
        rem <= '0;
        cnt <= CW'(SHW);
      end
      mau_pkg::OP_WB_RAW: begin
        res_q <= raw_q[SHW-1] ? neg_mod(rem, m_eff) : rem;
      end
      mau_pkg::OP_SIMPLE: begin
        case (mode_q)
          mau_pkg::MODE_ADD: res_q <= add_mod(ra, rb, m_eff);
          mau_pkg::MODE_SUB: res_q <= add_mod(ra, neg_mod(rb, m_eff), m_eff);
          default:           res_q <= neg_mod(ra, m_eff);
        endcase
      end
      mau_pkg::OP_MUL_AB: begin
        pa  <= '0;
        mx  <= ra;
        sh  <= {rb, {(SHW-W){1'b0}}};
        cnt <= CW'(W);
      end
      mau_pkg::OP_POW_ONE: begin
        res_q <= one;
      end
      mau_pkg::OP_POW_INIT: begin
        acc  <= one;
        ex_q <= {ex_q[SHW-2:0], 1'b0};
        ecnt <= ECW'(EW);
      end
      mau_pkg::OP_MUL_SQ: begin
        pa  <= '0;
        mx  <= acc;
        sh  <= {acc, {(SHW-W){1'b0}}};
        cnt <= CW'(W);
      end
      mau_pkg::OP_WB_ACC: begin
        acc <= pa;
      end
      mau_pkg::OP_MUL_BASE: begin
        pa  <= '0;
        mx  <= ra;
        sh  <= {acc, {(SHW-W){1'b0}}};
        cnt <= CW'(W);
      end
      mau_pkg::OP_EXP_SHIFT: begin
        ex_q <= {ex_q[SHW-2:0], 1'b0};
        ecnt <= ecnt - ECW'(1);
      end
      mau_pkg::OP_WB_ACC_SHIFT: begin
        acc  <= pa;
        ex_q <= {ex_q[SHW-2:0], 1'b0};
        ecnt <= ecnt - ECW'(1);
      end
      mau_pkg::OP_RES_ACC: begin
        res_q <= acc;
      end
      mau_pkg::OP_EUC_INIT: begin
        r0 <= m_eff;
        r1 <= (mode_q == mau_pkg::MODE_INV) ? ra : rb;
        t0 <= '0;
        t1 <= one;
      end
      mau_pkg::OP_EUC_DIV: begin
        sh  <= {r0, {(SHW-W){1'b0}}};
        rem <= '0;
        dv  <= r1;
        cnt <= CW'(W);
      end
      mau_pkg::OP_MUL_QT: begin
        // The quotient sits in the low bits of the shift register.
        r0  <= r1;
        r1  <= rem;
        pa  <= '0;
        mx  <= t1;
        sh  <= {sh[W-1:0], {(SHW-W){1'b0}}};
        cnt <= CW'(W);
      end
      mau_pkg::OP_EUC_T: begin
        t0 <= t1;
        t1 <= add_mod(t0, neg_mod(pa, m_eff), m_eff);
      end
      mau_pkg::OP_EUC_END: begin
        noinv_q <= (r0 != W'(1));
        res_q   <= (r0 == W'(1)) ? t0 : '0;
      end
      mau_pkg::OP_MUL_INV: begin
        pa  <= '0;
        mx  <= ra;
        sh  <= {t0, {(SHW-W){1'b0}}};
        cnt <= CW'(W);
      end
      mau_pkg::OP_WB_RES: begin
        res_q <= pa;
      end
      mau_pkg::OP_OUT: begin
        out_result     <= res_q;
        out_no_inverse <= noinv_q;
        out_equal      <= (ra == rb);
        out_less       <= (ra < rb);
      end
      default: begin
      end
    endcase
  end

  assign status.mode      = mode_q;
  assign status.cnt_zero  = (cnt == '0);
  assign status.ecnt_zero = (ecnt == '0);
  assign status.r1_zero   = (r1 == '0);
  assign status.r0_one    = (r0 == W'(1));
  assign status.ex_top    = ex_q[SHW-1];

endmodule

[hw/rtl/mau_controller.sv]
// ----------------------------------------------------------------------------
// mau_controller
// Sequencer of the modular arithmetic unit: issues one datapath command
// per cycle and owns the stream handshakes.
// ----------------------------------------------------------------------------
module mau_controller (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  mau_pkg::dp_status_t status,
  output mau_pkg::dp_op_t     cmd
);

  typedef enum logic [13:0] {
    S_IDLE     = 14'h0001,
    S_RED_A    = 14'h0002,
    S_RED_B    = 14'h0004,
    S_DISPATCH = 14'h0008,
    S_RAW      = 14'h0010,
    S_MUL_RES  = 14'h0020,
    S_POW_GO   = 14'h0040,
    S_POW_SQ   = 14'h0080,
    S_POW_CHK  = 14'h0100,
    S_POW_ML   = 14'h0200,
    S_EUC_TEST = 14'h0400,
    S_EUC_DIV  = 14'h0800,
    S_EUC_MUL  = 14'h1000,
    S_DONE     = 14'h2000
  } state_t;

  state_t state, state_next;
  logic   slot_free;

  assign slot_free = !out_valid || out_ready;
  assign in_ready  = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = mau_pkg::OP_NOP;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd        = mau_pkg::OP_LOAD;
          state_next = S_RED_A;
        end
      end
      S_RED_A: begin
        if (status.cnt_zero) begin
          cmd        = mau_pkg::OP_WB_RA;
          state_next = S_RED_B;
        end else begin
          cmd = mau_pkg::OP_DIV_STEP;
        end
      end
      S_RED_B: begin
        if (status.cnt_zero) begin
          cmd        = mau_pkg::OP_WB_RB;
          state_next = S_DISPATCH;
        end else begin
          cmd = mau_pkg::OP_DIV_STEP;
        end
      end
      S_DISPATCH: begin
        case (status.mode)
          mau_pkg::MODE_REDUCE: begin
            cmd        = mau_pkg::OP_DIV_RAW;
            state_next = S_RAW;
          end
          mau_pkg::MODE_ADD, mau_pkg::MODE_SUB, mau_pkg::MODE_NEG: begin
            cmd        = mau_pkg::OP_SIMPLE;
            state_next = S_DONE;
          end
          mau_pkg::MODE_MUL: begin
            cmd        = mau_pkg::OP_MUL_AB;
            state_next = S_MUL_RES;
          end
          mau_pkg::MODE_POW: begin
            // A negative exponent gives one straight away.
            if (status.ex_top) begin
              cmd        = mau_pkg::OP_POW_ONE;
              state_next = S_DONE;
            end else begin
              cmd        = mau_pkg::OP_POW_INIT;
              state_next = S_POW_GO;
            end
          end
          default: begin
            cmd        = mau_pkg::OP_EUC_INIT;
            state_next = S_EUC_TEST;
          end
        endcase
      end
      S_RAW: begin
        if (status.cnt_zero) begin
          cmd        = mau_pkg::OP_WB_RAW;
          state_next = S_DONE;
        end else begin
          cmd = mau_pkg::OP_DIV_STEP;
        end
      end
      S_MUL_RES: begin
        if (status.cnt_zero) begin
          cmd        = mau_pkg::OP_WB_RES;
          state_next = S_DONE;
        end else begin
          cmd = mau_pkg::OP_MUL_STEP;
        end
      end
      S_POW_GO: begin
        if (status.ecnt_zero) begin
          cmd        = mau_pkg::OP_RES_ACC;
          state_next = S_DONE;
        end else begin
          cmd        = mau_pkg::OP_MUL_SQ;
          state_next = S_POW_SQ;
        end
      end
      S_POW_SQ: begin
        if (status.cnt_zero) begin
          cmd        = mau_pkg::OP_WB_ACC;
          state_next = S_POW_CHK;
        end else begin
          cmd = mau_pkg::OP_MUL_STEP;
        end
      end
      S_POW_CHK: begin
        if (status.ex_top) begin
          cmd        = mau_pkg::OP_MUL_BASE;
          state_next = S_POW_ML;
        end else begin
          cmd        = mau_pkg::OP_EXP_SHIFT;
          state_next = S_POW_GO;
        end
      end
      S_POW_ML: begin
        if (status.cnt_zero) begin
          cmd        = mau_pkg::OP_WB_ACC_SHIFT;
          state_next = S_POW_GO;
        end else begin
          cmd = mau_pkg::OP_MUL_STEP;
        end
      end
      S_EUC_TEST: begin
        if (status.r1_zero) begin
          if (!status.r0_one || status.mode == mau_pkg::MODE_INV) begin
            cmd        = mau_pkg::OP_EUC_END;
            state_next = S_DONE;
          end else begin
            cmd        = mau_pkg::OP_MUL_INV;
            state_next = S_MUL_RES;
          end
        end else begin
          cmd        = mau_pkg::OP_EUC_DIV;
          state_next = S_EUC_DIV;
        end
      end
      S_EUC_DIV: begin
        if (status.cnt_zero) begin
          cmd        = mau_pkg::OP_MUL_QT;
          state_next = S_EUC_MUL;
        end else begin
          cmd = mau_pkg::OP_DIV_STEP;
        end
      end
      S_EUC_MUL: begin
        if (status.cnt_zero) begin
          cmd        = mau_pkg::OP_EUC_T;
          state_next = S_EUC_TEST;
        end else begin
          cmd = mau_pkg::OP_MUL_STEP;
        end
      end
      S_DONE: begin
        if (slot_free) begin
          cmd        = mau_pkg::OP_OUT;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd == mau_pkg::OP_OUT) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == S_RED_A))
    else $error("accepted word did not start operand reduction");

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_DONE))
    else $error("result word raised outside the done state");

  a_done_delivers: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && slot_free) |=> (state == S_IDLE && out_valid))
    else $error("finished result not loaded into the output register");

endmodule

[hw/rtl/modular_arithmetic_unit.sv]
// ----------------------------------------------------------------------------
// modular_arithmetic_unit
// Residue arithmetic modulo a configured modulus over stream channels.
// ----------------------------------------------------------------------------
// One word at a time. Each word first reduces both operands with a
// bit-serial divider. Add, subtract and negate then finish directly;
// reduce divides the magnitude of the raw value by the modulus; multiply
// runs the bit-serial modular multiplier once; power walks 63 exponent
// bits with one square and, for a set bit, one multiply; inverse and
// divide run extended Euclid, each step one division and one multiply,
// with the step count set by the data.
// The result register lets the next word enter while a result waits.
module modular_arithmetic_unit #(
  parameter int RESIDUE_BITS = mau_pkg::RESIDUE_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_wr_en,
  input  logic [RESIDUE_BITS-1:0] cfg_wr_data,
  input  logic                    s_axis_tvalid,
  output logic                    s_axis_tready,
  // mode, operand_a, operand_b, raw_value, exponent, zero pad
  input  logic [((mau_pkg::MODE_BITS + 2*RESIDUE_BITS + 2*mau_pkg::RAW_BITS + 7) / 8) * 8 - 1:0]
                                  s_axis_tdata,
  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  // result, no_inverse, equal, less, zero pad
  output logic [((RESIDUE_BITS + 3 + 7) / 8) * 8 - 1:0] m_axis_tdata
);

  localparam int W       = RESIDUE_BITS;
  localparam int MB      = mau_pkg::MODE_BITS;
  localparam int RB      = mau_pkg::RAW_BITS;
  localparam int OUT_W   = ((W + 3 + 7) / 8) * 8;
  localparam int A_LO    = MB;
  localparam int B_LO    = A_LO + W;
  localparam int RAW_LO  = B_LO + W;
  localparam int EXP_LO  = RAW_LO + RB;

  logic [W-1:0]        modulus;
  mau_pkg::dp_op_t     cmd;
  mau_pkg::dp_status_t status;
  logic [W-1:0]        out_result;
  logic                out_no_inverse, out_equal, out_less;

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= W'(1);
    end else if (cfg_wr_en) begin
      modulus <= cfg_wr_data;
    end
  end

  mau_controller u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .status    (status),
    .cmd       (cmd)
  );

  mau_datapath #(
    .RESIDUE_BITS (RESIDUE_BITS)
  ) u_dp (
    .clk            (clk),
    .cmd            (cmd),
    .status         (status),
    .modulus        (modulus),
    .in_mode        (s_axis_tdata[MB-1:0]),
    .in_operand_a   (s_axis_tdata[A_LO +: W]),
    .in_operand_b   (s_axis_tdata[B_LO +: W]),
    .in_raw_value   (s_axis_tdata[RAW_LO +: RB]),
    .in_exponent    (s_axis_tdata[EXP_LO +: RB]),
    .out_result     (out_result),
    .out_no_inverse (out_no_inverse),
    .out_equal      (out_equal),
    .out_less       (out_less)
  );

  assign m_axis_tdata = OUT_W'({out_less, out_equal, out_no_inverse, out_result});

endmodule
